/* design/scp_pkg.sv */
package scp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AccW = 16;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_NUMBER = 2'd1;
	localparam logic [1:0] PH_PULSE = 2'd2;
	localparam logic [1:0] PH_TIME = 2'd3;

	localparam logic [ByteW-1:0] CH_HASH = 8'h23;
	localparam logic [ByteW-1:0] CH_P = 8'h50;
	localparam logic [ByteW-1:0] CH_T = 8'h54;
	localparam logic [ByteW-1:0] CH_BANG = 8'h21;
	localparam logic [ByteW-1:0] CH_ZERO = 8'h30;

	typedef logic [AccW-1:0] acc_t;

	function automatic acc_t scp_mac10(input acc_t acc, input logic [ByteW-1:0] ch);
		acc_t times8;
		acc_t times2;
		times8 = {acc[AccW-4:0], 3'b000};
		times2 = {acc[AccW-2:0], 1'b0};
		return acc_t'(times8 + times2 + acc_t'(ch) - acc_t'(CH_ZERO));
	endfunction

endpackage

/* design/scp_if.sv */
interface scp_rx_if import scp_pkg::*; ();
	logic valid;
	logic ready;
	logic [ByteW-1:0] rx_byte;
	logic end_of_buffer;

	modport source(output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink(input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface scp_cmd_if import scp_pkg::*; ();
	logic valid;
	logic ready;
	acc_t servo_number;
	acc_t pulse_value;
	acc_t move_duration;

	modport source(output valid, output servo_number, output pulse_value,
		output move_duration, input ready);
	modport sink(input valid, input servo_number, input pulse_value,
		input move_duration, output ready);
endinterface

/* design/servo_command_text_parser.sv */
// Servo command text parser.
//
// The rx channel carries one character of command text per beat, such as
// "#000P1500T1000!", or an end-of-buffer mark that ends the string.
// The cmd channel carries one parsed command per beat: servo number, pulse
// value and move duration, each a 16-bit decimal accumulation modulo 2^16.
// A command is emitted by a '!' or an end-of-buffer mark in the time field.
//
// Throughput is one rx beat per cycle unless a command beat is stalled.
// A command beat is presented on the cycle after the beat that closes it,
// from the output register. The parse phase and the current field's
// accumulator update together, so only a stall cuts the character rate.
//
// Reset puts the parser in the idle phase, clears the accumulators and
// drops cmd valid. While a command waits on a stalled receiver, rx ready is
// low and no beat is taken, whether or not it would close a command; ready
// follows cmd ready whenever the output register is full.
module servo_command_text_parser import scp_pkg::*; (
	input logic clk,
	input logic arst_n,
	scp_rx_if.sink rx,
	scp_cmd_if.source cmd
);

	logic [1:0] phase_q;
	acc_t number_q;
	acc_t pulse_q;
	acc_t duration_q;
	logic out_valid_q;
	acc_t out_number_q;
	acc_t out_pulse_q;
	acc_t out_duration_q;

	logic accept;
	logic emit;

	assign rx.ready = !out_valid_q || cmd.ready;
	assign accept = rx.valid && rx.ready;
	assign emit = (phase_q == PH_TIME) && (rx.end_of_buffer || rx.rx_byte == CH_BANG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			number_q <= '0;
			pulse_q <= '0;
			duration_q <= '0;
		end else if (accept) begin
			if (rx.end_of_buffer) begin
				phase_q <= PH_IDLE;
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (rx.rx_byte == CH_HASH) begin
							number_q <= '0;
							phase_q <= PH_NUMBER;
						end else if (rx.rx_byte == CH_P) begin
							pulse_q <= '0;
							phase_q <= PH_PULSE;
						end else if (rx.rx_byte == CH_T) begin
							duration_q <= '0;
							phase_q <= PH_TIME;
						end
					end
					PH_NUMBER: begin
						if (rx.rx_byte == CH_P) begin
							pulse_q <= '0;
							phase_q <= PH_PULSE;
						end else begin
							number_q <= scp_mac10(number_q, rx.rx_byte);
						end
					end
					PH_PULSE: begin
						if (rx.rx_byte == CH_T) begin
							duration_q <= '0;
							phase_q <= PH_TIME;
						end else begin
							pulse_q <= scp_mac10(pulse_q, rx.rx_byte);
						end
					end
					default: begin
						if (rx.rx_byte == CH_BANG) begin
							phase_q <= PH_IDLE;
						end else begin
							duration_q <= scp_mac10(duration_q, rx.rx_byte);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_number_q <= number_q;
			out_pulse_q <= pulse_q;
			out_duration_q <= duration_q;
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.servo_number = out_number_q;
	assign cmd.pulse_value = out_pulse_q;
	assign cmd.move_duration = out_duration_q;

endmodule

/* design/scp_checker.sv */
module scp_checker import scp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	input logic rx_ready,
	input logic [ByteW-1:0] rx_byte,
	input logic rx_end_of_buffer,
	input logic cmd_valid,
	input logic cmd_ready,
	input acc_t cmd_servo_number,
	input acc_t cmd_pulse_value,
	input acc_t cmd_move_duration
);

	// A stalled command beat holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_servo_number)
			&& $stable(cmd_pulse_value) && $stable(cmd_move_duration))
		else $error("stalled command beat changed");

	// A new command beat follows an accepted '!' or end-of-buffer mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !$past(cmd_valid && !cmd_ready)
			|-> $past(rx_valid && rx_ready && (rx_end_of_buffer || rx_byte == CH_BANG)))
		else $error("command beat without a closing character");

	// The parser only stalls its input behind a stalled command beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> cmd_valid && !cmd_ready)
		else $error("input stalled without output backpressure");

	// A command beat leaves only after it has been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd_valid) |-> $past(cmd_ready))
		else $error("command beat dropped");

endmodule

bind servo_command_text_parser scp_checker u_scp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_valid(rx.valid),
	.rx_ready(rx.ready),
	.rx_byte(rx.rx_byte),
	.rx_end_of_buffer(rx.end_of_buffer),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_servo_number(cmd.servo_number),
	.cmd_pulse_value(cmd.pulse_value),
	.cmd_move_duration(cmd.move_duration)
);
